// ===== src/csq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semaphore and task-queue package
// Shared sizes, operation and status codes, state encoding and the record
// types that pass between the queue engine and the stream wrapper.
// ----------------------------------------------------------------------------
package csq_pkg;

	localparam int NUM_TASKS  = 16;
	localparam int NUM_SEMS   = 8;
	localparam int LINK_DEPTH = NUM_TASKS + 1;
	localparam int TID_W      = $clog2(NUM_TASKS + 1);
	localparam int STEP_W     = $clog2(NUM_TASKS + 1);
	localparam int SEM_AW     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int CNT_W      = 8;
	localparam int SEM_W      = CNT_W + TID_W;

	// Fixed field widths at the ports.
	localparam int OP_W       = 3;
	localparam int SEL_W      = 3;
	localparam int STAT_W     = 2;
	localparam int ID_W       = 5;
	localparam int ICNT_W     = 4;
	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 24;

	localparam logic [ICNT_W-1:0] ICNT_RESET = ICNT_W'(1);
	localparam logic [TID_W-1:0]  NO_TASK    = '0;
	localparam logic [TID_W-1:0]  FIRST_TASK = TID_W'(1);

	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_INIT   = 3'd0,
		OP_CREATE = 3'd1,
		OP_START  = 3'd2,
		OP_WAIT   = 3'd3,
		OP_SIGNAL = 3'd4
	} csq_op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_SLOT  = 2'd1,
		STAT_DEADLOCK = 2'd2
	} csq_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_APP_CHK,
		S_APP_STEP,
		S_APP_TAIL,
		S_POP_RD,
		S_POP_WT,
		S_SEM_RD,
		S_SEM_UPD,
		S_WPOP_RD,
		S_WPOP_WT,
		S_SEM_WB,
		S_DONE
	} csq_state_t;

	typedef struct packed {
		logic                    valid;
		csq_op_t                 op;
		logic [SEL_W-1:0]        sem;
	} csq_req_t;

	typedef struct packed {
		csq_status_t             status;
		logic [ID_W-1:0]         task_id;
		logic                    blocked;
		logic [ID_W-1:0]         woken_task;
		logic signed [CNT_W-1:0] sem_value;
	} csq_result_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] cnt;
		logic [TID_W-1:0]        whead;
	} csq_sem_t;

	// A task id beyond the table reads as no task.
	function automatic logic [TID_W-1:0] safe_id(input logic [TID_W-1:0] t);
		return (32'(t) <= NUM_TASKS) ? t : NO_TASK;
	endfunction

	function automatic logic [ID_W-1:0] out_id(input logic [TID_W-1:0] t);
		return ID_W'(t);
	endfunction

endpackage

// ===== src/csq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module csq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/csq_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semaphore and task-queue engine
// Sequencer that reads, updates and writes back the link table and the
// semaphore table, walking lists to their tails for appends.
// ----------------------------------------------------------------------------
module csq_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  csq_pkg::csq_req_t          req,
	output logic                       idle,
	input  logic [csq_pkg::ICNT_W-1:0] init_cnt,
	output logic                       res_valid,
	input  logic                       res_ready,
	output csq_pkg::csq_result_t       res
);
	import csq_pkg::*;

	csq_state_t state_q, state_d;

	// Control state.
	logic [TID_W-1:0]      ready_head_q;
	logic [TID_W-1:0]      current_q;
	logic [LINK_DEPTH-1:0] used_q;
	logic [LINK_DEPTH-1:0] link_vld_q;
	logic [NUM_SEMS-1:0]   sem_vld_q;
	logic [ICNT_W-1:0]     init_cnt_q;

	// Working registers.
	csq_op_t                 op_q;
	logic [SEL_W-1:0]        sem_q;
	logic [TID_W-1:0]        scan_q;
	logic [STEP_W-1:0]       steps_q;
	logic [TID_W-1:0]        p_q;
	logic [TID_W-1:0]        app_tid_q;
	logic                    app_to_wait_q;
	logic signed [CNT_W-1:0] cnt_q;
	logic [TID_W-1:0]        whead_q;
	logic [TID_W-1:0]        pop_t_q;
	logic [TID_W-1:0]        woken_q;
	csq_status_t             status_q;
	logic [TID_W-1:0]        tid_q;
	logic                    blocked_q;
	logic                    link_vld_s1;
	logic                    sem_vld_s1;

	// Memory ports.
	logic              link_we;
	logic [TID_W-1:0]  link_waddr;
	logic [TID_W-1:0]  link_wdata;
	logic [TID_W-1:0]  link_raddr;
	logic [TID_W-1:0]  link_rdata;
	logic              sem_we;
	logic [SEM_AW-1:0] sem_addr;
	logic [SEM_W-1:0]  sem_rdata;

	// Helpers.
	logic [TID_W-1:0]        app_head;
	logic [TID_W-1:0]        app_p;
	logic [TID_W-1:0]        link_rd;
	logic [TID_W-1:0]        link_nxt;
	logic                    walk_more;
	logic [TID_W-1:0]        pop_t;
	csq_sem_t                sem_rd;
	csq_sem_t                sem_dflt;
	logic signed [CNT_W-1:0] ncnt;
	logic                    wake;
	logic                    req_sem_ok;
	csq_state_t              app_cont;
	csq_state_t              pop_cont;

	assign sem_addr = SEM_AW'(sem_q);

	csq_ram #(.WIDTH(TID_W), .DEPTH(LINK_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	csq_ram #(.WIDTH(SEM_W), .DEPTH(NUM_SEMS)) u_sem_ram (
		.clk   (clk),
		.we    (sem_we),
		.waddr (sem_addr),
		.wdata ({cnt_q, whead_q}),
		.raddr (sem_addr),
		.rdata (sem_rdata)
	);

	always_comb begin
		app_head   = app_to_wait_q ? whead_q : ready_head_q;
		app_p      = safe_id(app_head);
		link_rd    = link_vld_s1 ? link_rdata : NO_TASK;
		link_nxt   = safe_id(link_rd);
		walk_more  = (link_nxt != NO_TASK) && (32'(steps_q) < NUM_TASKS);
		pop_t      = safe_id(ready_head_q);
		req_sem_ok = 32'(req.sem) < NUM_SEMS;
		sem_dflt.cnt   = $signed({{(CNT_W-ICNT_W){1'b0}}, init_cnt_q});
		sem_dflt.whead = NO_TASK;
		sem_rd = sem_vld_s1 ? csq_sem_t'(sem_rdata) : sem_dflt;
		if (op_q == OP_WAIT) begin
			ncnt = (sem_rd.cnt != CNT_MIN) ? sem_rd.cnt - CNT_ONE : sem_rd.cnt;
		end else begin
			ncnt = (sem_rd.cnt != CNT_MAX) ? sem_rd.cnt + CNT_ONE : sem_rd.cnt;
		end
		wake = (ncnt[CNT_W-1] || (ncnt == '0)) && (safe_id(sem_rd.whead) != NO_TASK);
		case (op_q)
			OP_WAIT:   app_cont = S_POP_RD;
			OP_SIGNAL: app_cont = S_SEM_WB;
			default:   app_cont = S_DONE;
		endcase
		pop_cont = (op_q == OP_WAIT) ? S_SEM_WB : S_DONE;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req.op)
						OP_INIT:   state_d = S_INIT;
						OP_CREATE: state_d = S_SCAN;
						OP_START:  state_d = S_POP_RD;
						OP_WAIT, OP_SIGNAL: state_d = req_sem_ok ? S_SEM_RD : S_DONE;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_INIT: state_d = S_DONE;
			S_SCAN: begin
				if (!used_q[scan_q]) begin
					state_d = S_APP_CHK;
				end else if (32'(scan_q) == NUM_TASKS) begin
					state_d = S_DONE;
				end
			end
			S_APP_CHK: begin
				if ((app_tid_q == NO_TASK) || (app_p == NO_TASK)) begin
					state_d = app_cont;
				end else begin
					state_d = S_APP_STEP;
				end
			end
			S_APP_STEP: state_d = walk_more ? S_APP_STEP : S_APP_TAIL;
			S_APP_TAIL: state_d = app_cont;
			S_POP_RD:   state_d = (pop_t == NO_TASK) ? pop_cont : S_POP_WT;
			S_POP_WT:   state_d = pop_cont;
			S_SEM_RD:   state_d = S_SEM_UPD;
			S_SEM_UPD: begin
				if (op_q == OP_WAIT) begin
					state_d = ncnt[CNT_W-1] ? S_APP_CHK : S_SEM_WB;
				end else begin
					state_d = wake ? S_WPOP_RD : S_SEM_WB;
				end
			end
			S_WPOP_RD: state_d = S_WPOP_WT;
			S_WPOP_WT: state_d = S_APP_CHK;
			S_SEM_WB:  state_d = S_DONE;
			S_DONE:    state_d = res_ready ? S_IDLE : S_DONE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Memory controls and handshake outputs.
	always_comb begin
		link_we    = 1'b0;
		link_waddr = p_q;
		link_wdata = NO_TASK;
		link_raddr = p_q;
		sem_we     = 1'b0;
		unique case (state_q)
			S_APP_CHK: begin
				if ((app_tid_q != NO_TASK) && (app_p == NO_TASK)) begin
					link_we    = 1'b1;
					link_waddr = app_tid_q;
				end else begin
					link_raddr = app_p;
				end
			end
			S_APP_STEP: begin
				if (walk_more) begin
					link_raddr = link_nxt;
				end else begin
					link_we    = 1'b1;
					link_wdata = app_tid_q;
				end
			end
			S_APP_TAIL: begin
				link_we    = 1'b1;
				link_waddr = app_tid_q;
			end
			S_POP_RD:  link_raddr = pop_t;
			S_WPOP_RD: link_raddr = whead_q;
			S_SEM_WB:  sem_we = 1'b1;
			default: begin
			end
		endcase
		idle      = (state_q == S_IDLE);
		res_valid = (state_q == S_DONE);
	end

	assign res.status     = status_q;
	assign res.task_id    = out_id(tid_q);
	assign res.blocked    = blocked_q;
	assign res.woken_task = out_id(woken_q);
	assign res.sem_value  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ready_head_q <= NO_TASK;
			current_q    <= NO_TASK;
			used_q       <= '0;
			link_vld_q   <= '0;
			sem_vld_q    <= '0;
			init_cnt_q   <= ICNT_RESET;
		end else begin
			state_q <= state_d;
			if (link_we) begin
				link_vld_q[link_waddr] <= 1'b1;
			end
			if (sem_we) begin
				sem_vld_q[sem_addr] <= 1'b1;
			end
			unique case (state_q)
				S_INIT: begin
					ready_head_q <= NO_TASK;
					current_q    <= NO_TASK;
					used_q       <= '0;
					link_vld_q   <= '0;
					sem_vld_q    <= '0;
					init_cnt_q   <= init_cnt;
				end
				S_SCAN: begin
					if (!used_q[scan_q]) begin
						used_q[scan_q] <= 1'b1;
					end
				end
				S_APP_CHK: begin
					if ((app_tid_q != NO_TASK) && (app_p == NO_TASK) && !app_to_wait_q) begin
						ready_head_q <= app_tid_q;
					end
				end
				S_POP_RD: begin
					if (pop_t == NO_TASK) begin
						current_q <= NO_TASK;
					end
				end
				S_POP_WT: begin
					ready_head_q <= link_nxt;
					current_q    <= pop_t_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		link_vld_s1 <= link_vld_q[link_raddr];
		sem_vld_s1  <= sem_vld_q[sem_addr];
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_q      <= req.op;
					sem_q     <= req.sem;
					scan_q    <= FIRST_TASK;
					status_q  <= STAT_OK;
					tid_q     <= NO_TASK;
					blocked_q <= 1'b0;
					woken_q   <= NO_TASK;
					cnt_q     <= '0;
				end
			end
			S_SCAN: begin
				if (!used_q[scan_q]) begin
					tid_q         <= scan_q;
					app_tid_q     <= scan_q;
					app_to_wait_q <= 1'b0;
				end else if (32'(scan_q) == NUM_TASKS) begin
					status_q <= STAT_NO_SLOT;
				end else begin
					scan_q <= scan_q + FIRST_TASK;
				end
			end
			S_APP_CHK: begin
				p_q     <= app_p;
				steps_q <= '0;
				if ((app_tid_q != NO_TASK) && (app_p == NO_TASK) && app_to_wait_q) begin
					whead_q <= app_tid_q;
				end
			end
			S_APP_STEP: begin
				if (walk_more) begin
					p_q     <= link_nxt;
					steps_q <= steps_q + STEP_W'(1);
				end
			end
			S_POP_RD: begin
				pop_t_q <= pop_t;
				if (pop_t == NO_TASK) begin
					status_q <= STAT_DEADLOCK;
					tid_q    <= NO_TASK;
				end
			end
			S_POP_WT: tid_q <= pop_t_q;
			S_SEM_UPD: begin
				cnt_q   <= ncnt;
				whead_q <= sem_rd.whead;
				if (op_q == OP_WAIT) begin
					if (ncnt[CNT_W-1]) begin
						blocked_q     <= 1'b1;
						app_tid_q     <= safe_id(current_q);
						app_to_wait_q <= 1'b1;
					end else begin
						tid_q <= current_q;
					end
				end
			end
			S_WPOP_RD: woken_q <= whead_q;
			S_WPOP_WT: begin
				whead_q       <= link_nxt;
				app_tid_q     <= woken_q;
				app_to_wait_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_ready_head_safe: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ready_head_q) <= NUM_TASKS)
		else $error("ready list head outside the task table");

	a_init_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |=> (ready_head_q == NO_TASK && current_q == NO_TASK
			&& used_q == '0 && link_vld_q == '0))
		else $error("init left list state behind");

	a_link_write_safe: assert property (@(posedge clk) disable iff (!arst_n)
		link_we |-> (32'(link_waddr) <= NUM_TASKS && 32'(link_wdata) <= NUM_TASKS))
		else $error("link table written with an id outside the table");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APP_STEP) |-> (32'(steps_q) <= NUM_TASKS))
		else $error("list walk exceeded its step limit");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("finished result dropped before transfer");
`endif

endmodule

// ===== src/counting_semaphore_task_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore and task-queue unit
// Stream front end for the semaphore engine: input transfer, result register
// and the initial count register.
// ----------------------------------------------------------------------------
// One operation is handled at a time; the sequencer waits on the registered
// reads of the link and semaphore memories. Init clears the tables at once
// by their valid bits, so there is no clearing pass. Create scans for the
// lowest free slot, then walks the ready list and links the new task at its
// tail. P and V take longer when a task is queued or woken: one list walk
// and one pop. The next operation may be transferred as soon as the
// previous result has been handed to the result register, so a waiting
// result does not hold up the input side.
// ----------------------------------------------------------------------------
module counting_semaphore_task_queue_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input operations.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [csq_pkg::S_TDATA_W-1:0] s_tdata,  // [2:0] sem_index, rest zero
	input  logic [csq_pkg::OP_W-1:0]      s_tuser,  // [2:0] operation
	// Results.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [csq_pkg::M_TDATA_W-1:0] m_tdata,  // [1:0] status, [6:2] task_id,
	                                                // [7] blocked, [12:8] woken_task,
	                                                // [20:13] sem_value, rest zero
	// Initial count register.
	input  logic                          cfg_we,
	input  logic [csq_pkg::ICNT_W-1:0]    cfg_wdata
);
	import csq_pkg::*;

	logic [ICNT_W-1:0] init_cnt_q;
	csq_req_t          req;
	logic              eng_idle;
	logic              res_valid;
	logic              res_ready;
	csq_result_t       res;
	logic              m_tvalid_q;
	csq_result_t       out_q;

	// The count register is written straight from the port; init samples it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= ICNT_RESET;
		end else if (cfg_we) begin
			init_cnt_q <= cfg_wdata;
		end
	end

	// The engine takes a new operation whenever it is idle.
	assign s_tready  = eng_idle;
	assign req.valid = s_tvalid && eng_idle;
	assign req.op    = csq_op_t'(s_tuser);
	assign req.sem   = s_tdata[SEL_W-1:0];

	csq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.idle      (eng_idle),
		.init_cnt  (init_cnt_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The result register loads when it is empty or its contents are being
	// transferred in the same cycle.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {
		{(M_TDATA_W - STAT_W - 2*ID_W - 1 - CNT_W){1'b0}},
		out_q.sem_value,
		out_q.woken_task,
		out_q.blocked,
		out_q.task_id,
		out_q.status
	};

endmodule
